// ===== sv/grl_pkg.sv =====
// grl_pkg: sizes, types, codes and helper functions of the grid region labeling unit
// used by grid_region_labeling_unit and grl_checker; no dependencies
`default_nettype none

package grl_pkg;

   // grid store size
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;

   // derived widths
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
   localparam int COLS_W  = $clog2(MAX_COLS + 1);
   localparam int IDX_W   = $clog2(CELLS);
   localparam int SP_W    = $clog2(CELLS + 1);

   // fixed field widths
   localparam int KIND_W    = 2;
   localparam int FIELD_W   = 5;
   localparam int SIZE_W    = 6;
   localparam int LABEL_W   = 10;
   localparam int CSR_IDX_W = 4;

   localparam logic [LABEL_W-1:0] LABEL_MAX       = 10'd1023;
   localparam logic [SIZE_W-1:0]  GRID_SIZE_RESET = 6'd32;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 4'd1;

   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic [ROWS_W-1:0]  rows_type;
   typedef logic [COLS_W-1:0]  cols_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [SP_W-1:0]    sp_type;
   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [SIZE_W-1:0]  size_type;

   // one fill stack entry
   typedef struct packed {
      row_type r;
      col_type c;
   } cell_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_NB_RD,
      ST_NB_CHK,
      ST_DONE
   } state_type;

   // neighbor visiting order
   typedef enum logic [1:0] {
      NB_UP,
      NB_DOWN,
      NB_RIGHT,
      NB_LEFT
   } nb_dir_type;

   // row-major store address
   function automatic idx_type cell_idx(row_type r, col_type c);
      return idx_type'(int'(r) * MAX_COLS + int'(c));
   endfunction

   // register value to active row count, 0 counts as 1
   function automatic rows_type clamp_rows(size_type v);
      rows_type res;
      if (v == '0) begin
         res = rows_type'(1);
      end else if (int'(v) > MAX_ROWS) begin
         res = rows_type'(MAX_ROWS);
      end else begin
         res = rows_type'(v);
      end
      return res;
   endfunction

   // register value to active column count, 0 counts as 1
   function automatic cols_type clamp_cols(size_type v);
      cols_type res;
      if (v == '0) begin
         res = cols_type'(1);
      end else if (int'(v) > MAX_COLS) begin
         res = cols_type'(MAX_COLS);
      end else begin
         res = cols_type'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/grid_region_labeling_unit.sv =====
// grid_region_labeling_unit: 4-connected region labeling over a stored wall grid
// depends on grl_pkg
`default_nettype none

// A write word stores one wall bit and does not block input; a read word returns the
// cell's label through the label memory read register and the result register. A run
// word blocks input until done: it first sweeps the label memory to zero, one entry a
// cycle, then scans the active grid with a read and a check step per cell, and for each
// labeled cell spends a stack pop step and a step on each of its four neighbors, plus a
// check step when the neighbor is inside the grid and its wall and label are fetched,
// with a further pop step per region when its stack runs empty, and a done step to post
// the result. All of this uses one label memory, one wall memory read port and one fill
// stack memory, under one state machine. Reads before the first run return label 0.
module grid_region_labeling_unit (
   input  wire                                clock,
   input  wire                                reset,
   // input words
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [grl_pkg::KIND_W-1:0]         req_kind,
   input  wire  [grl_pkg::FIELD_W-1:0]        req_cell_row,
   input  wire  [grl_pkg::FIELD_W-1:0]        req_cell_col,
   input  wire                                req_wall_bit,
   // result words
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [grl_pkg::LABEL_W-1:0]        rsp_cell_label,
   output logic [grl_pkg::LABEL_W-1:0]        rsp_region_total,
   // register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [grl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [grl_pkg::SIZE_W-1:0]         csr_wdata
);

   // control registers
   grl_pkg::state_type  state_ff, state_in;
   grl_pkg::size_type   grid_rows_ff, grid_rows_in;
   grl_pkg::size_type   grid_cols_ff, grid_cols_in;
   grl_pkg::rows_type   rows_ff, rows_in;
   grl_pkg::cols_type   cols_ff, cols_in;
   grl_pkg::row_type    scan_r_ff, scan_r_in;
   grl_pkg::col_type    scan_c_ff, scan_c_in;
   grl_pkg::idx_type    clr_ff, clr_in;
   grl_pkg::sp_type     sp_ff, sp_in;
   grl_pkg::label_type  region_ff, region_in;
   logic                ran_ff, ran_in;
   grl_pkg::nb_dir_type nb_ff, nb_in;
   grl_pkg::row_type    nb_r_ff, nb_r_in;
   grl_pkg::col_type    nb_c_ff, nb_c_in;
   logic                rd_inside_ff, rd_inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   grl_pkg::label_type  rsp_label_ff, rsp_label_in;
   grl_pkg::label_type  rsp_total_ff, rsp_total_in;

   // memories and their ports
   logic                wall_mem [grl_pkg::CELLS];
   grl_pkg::label_type  lab_mem  [grl_pkg::CELLS];
   grl_pkg::cell_type   stk_mem  [grl_pkg::CELLS];

   logic                wall_we;
   grl_pkg::idx_type    wall_waddr;
   logic                wall_rd_ff;
   logic                lab_we;
   grl_pkg::idx_type    lab_waddr;
   grl_pkg::label_type  lab_wdata;
   logic                lab_re;
   grl_pkg::idx_type    lab_raddr;
   grl_pkg::label_type  lab_rd_ff;
   logic                stk_we;
   grl_pkg::idx_type    stk_waddr;
   grl_pkg::cell_type   stk_wdata;
   logic                stk_re;
   grl_pkg::idx_type    stk_raddr;
   grl_pkg::cell_type   stk_rd_ff;

   // helper signals
   logic                req_needs_out;
   logic                req_fire;
   logic                req_inside;
   grl_pkg::idx_type    req_idx;
   grl_pkg::idx_type    scan_idx;
   logic                scan_col_last;
   logic                scan_last;
   grl_pkg::label_type  new_label;
   logic                cell_open;
   grl_pkg::sp_type     sp_dec;
   logic                nb_ok;
   grl_pkg::row_type    nb_r_calc;
   grl_pkg::col_type    nb_c_calc;

   // input side handshake
   always_comb begin
      req_needs_out = (req_kind == grl_pkg::KIND_RUN) || (req_kind == grl_pkg::KIND_READ);
      req_stall     = (state_ff != grl_pkg::ST_IDLE) ||
                      (req_needs_out && rsp_valid_ff && rsp_stall);
      req_fire      = req_valid && !req_stall;
      req_inside    = (int'(req_cell_row) < grl_pkg::MAX_ROWS) &&
                      (int'(req_cell_col) < grl_pkg::MAX_COLS);
      req_idx       = grl_pkg::cell_idx(grl_pkg::row_type'(req_cell_row),
                                        grl_pkg::col_type'(req_cell_col));
   end

   // scan position and neighbor selection
   always_comb begin
      scan_idx      = grl_pkg::cell_idx(scan_r_ff, scan_c_ff);
      scan_col_last = (int'(scan_c_ff) + 1) >= int'(cols_ff);
      scan_last     = scan_col_last && ((int'(scan_r_ff) + 1) >= int'(rows_ff));
      new_label     = (region_ff < grl_pkg::LABEL_MAX) ?
                      region_ff + grl_pkg::label_type'(1) : region_ff;
      cell_open     = !wall_rd_ff && (lab_rd_ff == '0);
      sp_dec        = sp_ff - grl_pkg::sp_type'(1);
      nb_ok         = 1'b0;
      nb_r_calc     = stk_rd_ff.r;
      nb_c_calc     = stk_rd_ff.c;
      case (nb_ff)
         grl_pkg::NB_UP: begin
            nb_ok     = stk_rd_ff.r != '0;
            nb_r_calc = stk_rd_ff.r - grl_pkg::row_type'(1);
         end
         grl_pkg::NB_DOWN: begin
            nb_ok     = (int'(stk_rd_ff.r) + 1) < int'(rows_ff);
            nb_r_calc = stk_rd_ff.r + grl_pkg::row_type'(1);
         end
         grl_pkg::NB_RIGHT: begin
            nb_ok     = (int'(stk_rd_ff.c) + 1) < int'(cols_ff);
            nb_c_calc = stk_rd_ff.c + grl_pkg::col_type'(1);
         end
         grl_pkg::NB_LEFT: begin
            nb_ok     = stk_rd_ff.c != '0;
            nb_c_calc = stk_rd_ff.c - grl_pkg::col_type'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // sequencer: next state, register updates and memory controls
   always_comb begin
      state_in     = state_ff;
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      scan_r_in    = scan_r_ff;
      scan_c_in    = scan_c_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      region_in    = region_ff;
      ran_in       = ran_ff;
      nb_in        = nb_ff;
      nb_r_in      = nb_r_ff;
      nb_c_in      = nb_c_ff;
      rd_inside_in = rd_inside_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_label_in = rsp_label_ff;
      rsp_total_in = rsp_total_ff;

      wall_we      = 1'b0;
      wall_waddr   = req_idx;
      lab_we       = 1'b0;
      lab_waddr    = scan_idx;
      lab_wdata    = '0;
      lab_re       = 1'b0;
      lab_raddr    = scan_idx;
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[grl_pkg::IDX_W-1:0];
      stk_wdata    = '{r: scan_r_ff, c: scan_c_ff};
      stk_re       = 1'b0;
      stk_raddr    = sp_dec[grl_pkg::IDX_W-1:0];

      // register writes
      csr_ready = 1'b1;
      if (csr_valid) begin
         if (csr_index == grl_pkg::CSR_GRID_ROWS) begin
            grid_rows_in = csr_wdata;
         end else if (csr_index == grl_pkg::CSR_GRID_COLS) begin
            grid_cols_in = csr_wdata;
         end
      end

      case (state_ff)
         grl_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == grl_pkg::KIND_WRITE) begin
                  wall_we = req_inside;
               end else if (req_kind == grl_pkg::KIND_READ) begin
                  lab_re       = 1'b1;
                  lab_raddr    = req_idx;
                  rd_inside_in = req_inside;
                  state_in     = grl_pkg::ST_READ;
               end else if (req_kind == grl_pkg::KIND_RUN) begin
                  rows_in   = grl_pkg::clamp_rows(grid_rows_ff);
                  cols_in   = grl_pkg::clamp_cols(grid_cols_ff);
                  scan_r_in = '0;
                  scan_c_in = '0;
                  clr_in    = '0;
                  sp_in     = '0;
                  region_in = '0;
                  ran_in    = 1'b1;
                  state_in  = grl_pkg::ST_CLEAR;
               end
            end
         end
         grl_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_label_in = (ran_ff && rd_inside_ff) ? lab_rd_ff : '0;
            rsp_total_in = region_ff;
            state_in     = grl_pkg::ST_IDLE;
         end
         grl_pkg::ST_CLEAR: begin
            // one label entry zeroed per cycle
            lab_we    = 1'b1;
            lab_waddr = clr_ff;
            lab_wdata = '0;
            clr_in    = clr_ff + grl_pkg::idx_type'(1);
            if (clr_ff == grl_pkg::idx_type'(grl_pkg::CELLS - 1)) begin
               state_in = grl_pkg::ST_SCAN_RD;
            end
         end
         grl_pkg::ST_SCAN_RD: begin
            lab_re    = 1'b1;
            lab_raddr = scan_idx;
            state_in  = grl_pkg::ST_SCAN_CHK;
         end
         grl_pkg::ST_SCAN_CHK: begin
            if (cell_open) begin
               // seed of a new region
               region_in = new_label;
               lab_we    = 1'b1;
               lab_waddr = scan_idx;
               lab_wdata = new_label;
               stk_we    = 1'b1;
               stk_wdata = '{r: scan_r_ff, c: scan_c_ff};
               sp_in     = sp_ff + grl_pkg::sp_type'(1);
               state_in  = grl_pkg::ST_POP;
            end else if (scan_last) begin
               state_in = grl_pkg::ST_DONE;
            end else begin
               if (scan_col_last) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + grl_pkg::row_type'(1);
               end else begin
                  scan_c_in = scan_c_ff + grl_pkg::col_type'(1);
               end
               state_in = grl_pkg::ST_SCAN_RD;
            end
         end
         grl_pkg::ST_POP: begin
            if (sp_ff != '0) begin
               stk_re   = 1'b1;
               sp_in    = sp_dec;
               nb_in    = grl_pkg::NB_UP;
               state_in = grl_pkg::ST_NB_RD;
            end else if (scan_last) begin
               state_in = grl_pkg::ST_DONE;
            end else begin
               // region finished, resume the scan
               if (scan_col_last) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + grl_pkg::row_type'(1);
               end else begin
                  scan_c_in = scan_c_ff + grl_pkg::col_type'(1);
               end
               state_in = grl_pkg::ST_SCAN_RD;
            end
         end
         grl_pkg::ST_NB_RD: begin
            if (nb_ok) begin
               lab_re    = 1'b1;
               lab_raddr = grl_pkg::cell_idx(nb_r_calc, nb_c_calc);
               nb_r_in   = nb_r_calc;
               nb_c_in   = nb_c_calc;
               state_in  = grl_pkg::ST_NB_CHK;
            end else if (nb_ff == grl_pkg::NB_LEFT) begin
               state_in = grl_pkg::ST_POP;
            end else begin
               nb_in = grl_pkg::nb_dir_type'(nb_ff + 2'd1);
            end
         end
         grl_pkg::ST_NB_CHK: begin
            if (cell_open) begin
               lab_we    = 1'b1;
               lab_waddr = grl_pkg::cell_idx(nb_r_ff, nb_c_ff);
               lab_wdata = region_ff;
               stk_we    = 1'b1;
               stk_wdata = '{r: nb_r_ff, c: nb_c_ff};
               sp_in     = sp_ff + grl_pkg::sp_type'(1);
            end
            if (nb_ff == grl_pkg::NB_LEFT) begin
               state_in = grl_pkg::ST_POP;
            end else begin
               nb_in    = grl_pkg::nb_dir_type'(nb_ff + 2'd1);
               state_in = grl_pkg::ST_NB_RD;
            end
         end
         grl_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_label_in = '0;
            rsp_total_in = region_ff;
            state_in     = grl_pkg::ST_IDLE;
         end
         default: begin
            state_in = grl_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grl_pkg::ST_IDLE;
         grid_rows_ff <= grl_pkg::GRID_SIZE_RESET;
         grid_cols_ff <= grl_pkg::GRID_SIZE_RESET;
         sp_ff        <= '0;
         region_ff    <= '0;
         ran_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         sp_ff        <= sp_in;
         region_ff    <= region_in;
         ran_ff       <= ran_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and result word
   always_ff @(posedge clock) begin
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      scan_r_ff    <= scan_r_in;
      scan_c_ff    <= scan_c_in;
      clr_ff       <= clr_in;
      nb_ff        <= nb_in;
      nb_r_ff      <= nb_r_in;
      nb_c_ff      <= nb_c_in;
      rd_inside_ff <= rd_inside_in;
      rsp_label_ff <= rsp_label_in;
      rsp_total_ff <= rsp_total_in;
   end

   // wall and label memories, shared read address
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[wall_waddr] <= req_wall_bit;
      end
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      if (lab_re) begin
         lab_rd_ff  <= lab_mem[lab_raddr];
         wall_rd_ff <= wall_mem[lab_raddr];
      end
   end

   // fill stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_label   = rsp_label_ff;
   assign rsp_region_total = rsp_total_ff;

endmodule

`default_nettype wire

// ===== sv/grl_checker.sv =====
// grl_port_checks: port-level checks of grid_region_labeling_unit, bound to the top level
// depends on grl_pkg
`default_nettype none

module grl_port_checks (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire [grl_pkg::KIND_W-1:0]    req_kind,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [grl_pkg::LABEL_W-1:0]   rsp_cell_label,
   input wire [grl_pkg::LABEL_W-1:0]   rsp_region_total
);

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_label) &&
                                 $stable(rsp_region_total))
      else $error("stalled result word changed");

   // a taken read word gives a valid result word through the label read and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == grl_pkg::KIND_READ |=> ##1 rsp_valid)
      else $error("read word gave no result");

   // a run word keeps input stalled while it works
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == grl_pkg::KIND_RUN |=> req_stall)
      else $error("input taken right after a run word");

   // no label exceeds the region count of the last run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_label <= rsp_region_total)
      else $error("label above region count");

endmodule

bind grid_region_labeling_unit grl_port_checks u_grl_checker (.*);

`default_nettype wire
